// ===== design/chs_pkg.sv =====
package chs_pkg;

  // Default number of fraction bits of every fixed-point value.
  localparam int FRAC_BITS_DEF = 16;

  // Coefficients of p(t) = c0 + c1 t + c2 t^2 + c3 t^3.
  localparam int COEFF_COUNT = 4;
  localparam int CI_POS  = 0;
  localparam int CI_VEL  = 1;
  localparam int CI_QUAD = 2;
  localparam int CI_CUBE = 3;

  // Minimum duration register.
  localparam int MIN_DUR_W = 17;
  localparam logic [MIN_DUR_W-1:0] MIN_DUR_RESET = 17'd1;

  // Request operations.
  localparam logic OP_PLAN   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic signed [63:0] coef_t;

  localparam coef_t S64_MAX = {1'b0, {63{1'b1}}};
  localparam coef_t S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic [31:0] S32_MIN = {1'b1, {31{1'b0}}};

  typedef struct packed {
    logic               op;
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] end_vel;
    logic [30:0]        duration;
    logic [30:0]        sample_time;
  } req_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_NUMER,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // Multiply steps: the first four plan a segment, the rest sample it.
  typedef enum logic [3:0] {
    MS_W0,
    MS_W1,
    MS_PT2,
    MS_PT3,
    MS_ST2,
    MS_ST3,
    MS_POS1,
    MS_POS2,
    MS_POS3,
    MS_VEL1,
    MS_VEL2,
    MS_ACC
  } mstep_t;

  // Magnitude of a signed 64-bit value; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input coef_t x);
    logic [63:0] m;
    m = x[63] ? (64'd0 - x) : x;
    return m;
  endfunction

  // Apply a sign to a magnitude and saturate to the signed 64-bit range.
  function automatic coef_t sat_mag(input logic neg, input logic hi_nz,
                                    input logic [63:0] mag);
    coef_t r;
    if (hi_nz || mag[63]) begin
      r = neg ? S64_MIN : S64_MAX;
    end else begin
      r = neg ? coef_t'(64'd0 - mag) : coef_t'(mag);
    end
    return r;
  endfunction

endpackage

// ===== design/chs_mul.sv =====
module chs_mul #(
  parameter int FRAC_BITS = chs_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  chs_pkg::coef_t a,
  input  chs_pkg::coef_t b,
  output logic          done,
  output chs_pkg::coef_t result
);
  import chs_pkg::*;

  localparam logic [2:0] IDX_PP_LAST   = 3'd3;
  localparam logic [2:0] IDX_ACC_FIRST = 3'd1;
  localparam logic [2:0] IDX_ACC_LAST  = 3'd4;
  localparam logic [2:0] IDX_FINAL     = 3'd5;

  logic         busy;
  logic [2:0]   idx;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;
  logic [31:0]  half_a;
  logic [31:0]  half_b;

  // Pick the 32-bit halves for this partial product.
  assign half_a = idx[1] ? ua[63:32] : ua[31:0];
  assign half_b = idx[0] ? ub[63:32] : ub[31:0];

  // Sequence control: four partial products, then a final step to round and saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 3'd1;
        if (idx == IDX_FINAL) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Magnitude datapath: one 32x32 product a cycle, accumulated the cycle after.
  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= mag64(a);
      ub  <= mag64(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      if (idx <= IDX_PP_LAST) begin
        pp    <= {32'd0, half_a} * {32'd0, half_b};
        pp_sh <= {1'b0, idx[1]} + {1'b0, idx[0]};
      end
      if (idx >= IDX_ACC_FIRST && idx <= IDX_ACC_LAST) begin
        acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
      end
      if (idx == IDX_FINAL) begin
        result <= sat_mag(neg, |acc[127:64+FRAC_BITS], acc[FRAC_BITS +: 64]);
      end
    end
  end

endmodule

// ===== design/chs_div.sv =====
module chs_div #(
  parameter int FRAC_BITS = chs_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  chs_pkg::coef_t num,
  input  logic [63:0]    den,
  output logic           done,
  output chs_pkg::coef_t quot
);
  import chs_pkg::*;

  localparam int DVD_W = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [63:0]      rem;
  logic [63:0]      q;
  logic [63:0]      d;
  logic             ovf;
  logic             neg;
  logic [64:0]      trial;
  logic [64:0]      diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, d};
  assign ge    = trial >= {1'b0, d};

  // Control: a zero divisor finishes at once, otherwise one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 64'd0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(DVD_W);
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // Quotient datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {mag64(num), {FRAC_BITS{1'b0}}};
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      neg <= num[63];
      d   <= den;
      if (den == 64'd0) begin
        quot <= (num == '0) ? '0 : (num[63] ? S64_MIN : S64_MAX);
      end
    end else if (busy) begin
      if (cnt == '0) begin
        quot <= sat_mag(neg, ovf, q);
      end else begin
        rem <= ge ? diff[63:0] : trial[63:0];
        q   <= {q[62:0], ge};
        ovf <= ovf | q[63];
        dvd <= dvd << 1;
      end
    end
  end

endmodule

// ===== design/cubic_hermite_segment_unit.sv =====
// Channel   Signals                          Direction  Moves
// request   req_valid, req_stall, req        in         plan or sample request
// result    res_valid, res_stall, res        out        sampled position, velocity, accel
// config    min_duration_we, _wdata          in         minimum duration register
//
// A sample request runs eight products through the shared multiplier. A plan request
// runs four products, then two divisions in the bit-serial divider. A short-duration plan
// loads the end position and velocity as coefficients and leaves the block idle.
// Reset is synchronous; it clears the coefficients and sets the minimum duration to one LSB.
// A stalled result holds in the output register; the block still takes the next request,
// and a following sample waits in its last step until the register is free.
module cubic_hermite_segment_unit #(
  parameter int FRAC_BITS = chs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  chs_pkg::req_t                   req,
  output logic                            res_valid,
  input  logic                            res_stall,
  output chs_pkg::res_t                   res,
  input  logic                            min_duration_we,
  input  logic [chs_pkg::MIN_DUR_W-1:0]   min_duration_wdata
);
  import chs_pkg::*;

  state_t               state;
  state_t               state_next;
  mstep_t               step;
  logic [MIN_DUR_W-1:0] min_dur;
  coef_t                coef [COEFF_COUNT];

  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] v0;
  logic signed [31:0] v1;
  logic [30:0]        tm;
  coef_t              tq2;
  coef_t              tq3;
  coef_t              w0;
  coef_t              w1;
  coef_t              n2;
  coef_t              n3;
  coef_t              pos;
  coef_t              vel;
  coef_t              acc;
  logic               div_second;

  logic        req_take;
  logic        plan_short;
  logic        emit_load;
  logic        mul_start;
  logic        mul_done;
  coef_t       mul_a;
  coef_t       mul_b;
  coef_t       mul_res;
  logic        div_start;
  logic        div_done;
  coef_t       div_num;
  logic [63:0] div_den;
  coef_t       div_quot;
  coef_t       tm_ext;
  logic [63:0] pdiff;

  // Saturate a 67-bit intermediate to the signed 64-bit range.
  function automatic coef_t clamp67(input logic [66:0] v);
    coef_t r;
    if ((v[66:63] == 4'b0000) || (v[66:63] == 4'b1111)) begin
      r = v[63:0];
    end else begin
      r = v[66] ? S64_MIN : S64_MAX;
    end
    return r;
  endfunction

  function automatic logic [66:0] sx67(input coef_t x);
    return {{3{x[63]}}, x};
  endfunction

  function automatic coef_t sat_add(input coef_t x, input coef_t y);
    return clamp67(sx67(x) + sx67(y));
  endfunction

  function automatic coef_t sat_x2(input coef_t x);
    return clamp67({{2{x[63]}}, x, 1'b0});
  endfunction

  function automatic coef_t sat_x3(input coef_t x);
    return clamp67({{2{x[63]}}, x, 1'b0} + sx67(x));
  endfunction

  function automatic coef_t sat_x6(input coef_t x);
    return clamp67({x[63], x, 2'b00} + {{2{x[63]}}, x, 1'b0});
  endfunction

  // Saturate to the 32-bit output range.
  function automatic logic [31:0] out32(input coef_t x);
    logic [31:0] r;
    if ((x[63:31] == '0) || (x[63:31] == '1)) begin
      r = x[31:0];
    end else begin
      r = x[63] ? S32_MIN : S32_MAX;
    end
    return r;
  endfunction

  assign plan_short = req.duration < {{(31-MIN_DUR_W){1'b0}}, min_dur};
  assign tm_ext     = {33'd0, tm};
  assign pdiff      = {{32{p1[31]}}, p1} - {{32{p0[31]}}, p0};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.op == OP_PLAN && plan_short) ? ST_IDLE : ST_MUL_GO;
        end
      end
      ST_MUL_GO: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (step == MS_PT3) begin
            state_next = ST_NUMER;
          end else if (step == MS_ACC) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_MUL_GO;
          end
        end
      end
      ST_NUMER: state_next = ST_DIV_GO;
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = div_second ? ST_IDLE : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_stall = (state != ST_IDLE);
    req_take  = (state == ST_IDLE) && req_valid;
    mul_start = (state == ST_MUL_GO);
    div_start = (state == ST_DIV_GO);
    emit_load = (state == ST_EMIT) && (!res_valid || !res_stall);
  end

  // Multiplier operands for each step.
  always_comb begin
    case (step)
      MS_W0:   begin mul_a = {{32{v0[31]}}, v0}; mul_b = tm_ext; end
      MS_W1:   begin mul_a = {{32{v1[31]}}, v1}; mul_b = tm_ext; end
      MS_PT2:  begin mul_a = tm_ext;             mul_b = tm_ext; end
      MS_PT3:  begin mul_a = tq2;                mul_b = tm_ext; end
      MS_ST2:  begin mul_a = tm_ext;             mul_b = tm_ext; end
      MS_ST3:  begin mul_a = tq2;                mul_b = tm_ext; end
      MS_POS1: begin mul_a = coef[CI_VEL];       mul_b = tm_ext; end
      MS_POS2: begin mul_a = coef[CI_QUAD];      mul_b = tq2;    end
      MS_POS3: begin mul_a = coef[CI_CUBE];      mul_b = tq3;    end
      MS_VEL1: begin mul_a = coef[CI_QUAD];      mul_b = tm_ext; end
      MS_VEL2: begin mul_a = coef[CI_CUBE];      mul_b = tq2;    end
      MS_ACC:  begin mul_a = coef[CI_CUBE];      mul_b = tm_ext; end
      default: begin mul_a = '0;                 mul_b = '0;     end
    endcase
  end

  assign div_num = div_second ? n3 : n2;
  assign div_den = div_second ? tq3 : tq2;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      min_dur   <= MIN_DUR_RESET;
    end else begin
      state <= state_next;
      if (emit_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (min_duration_we) begin
        min_dur <= min_duration_wdata;
      end
    end
  end

  // Coefficient store: written by plan requests only.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEFF_COUNT; i++) begin
        coef[i] <= '0;
      end
    end else begin
      if (req_take && req.op == OP_PLAN) begin
        if (plan_short) begin
          coef[CI_POS]  <= {{32{req.end_pos[31]}}, req.end_pos};
          coef[CI_VEL]  <= {{32{req.end_vel[31]}}, req.end_vel};
          coef[CI_QUAD] <= '0;
          coef[CI_CUBE] <= '0;
        end else begin
          coef[CI_POS] <= {{32{req.start_pos[31]}}, req.start_pos};
          coef[CI_VEL] <= {{32{req.start_vel[31]}}, req.start_vel};
        end
      end
      if (state == ST_DIV_WAIT && div_done) begin
        if (div_second) begin
          coef[CI_CUBE] <= div_quot;
        end else begin
          coef[CI_QUAD] <= div_quot;
        end
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (req_take) begin
      p0   <= req.start_pos;
      p1   <= req.end_pos;
      v0   <= req.start_vel;
      v1   <= req.end_vel;
      tm   <= (req.op == OP_SAMPLE) ? req.sample_time : req.duration;
      step <= (req.op == OP_SAMPLE) ? MS_ST2 : MS_W0;
    end

    // Store each product where its step needs it, then move on.
    if (state == ST_MUL_WAIT && mul_done) begin
      case (step)
        MS_W0:   w0  <= mul_res;
        MS_W1:   w1  <= mul_res;
        MS_PT2:  tq2 <= mul_res;
        MS_PT3:  tq3 <= mul_res;
        MS_ST2:  tq2 <= mul_res;
        MS_ST3:  tq3 <= mul_res;
        MS_POS1: pos <= sat_add(coef[CI_POS], mul_res);
        MS_POS2: pos <= sat_add(pos, mul_res);
        MS_POS3: pos <= sat_add(pos, mul_res);
        MS_VEL1: vel <= sat_add(coef[CI_VEL], sat_x2(mul_res));
        MS_VEL2: vel <= sat_add(vel, sat_x3(mul_res));
        MS_ACC:  acc <= sat_add(sat_x2(coef[CI_QUAD]), sat_x6(mul_res));
        default: pos <= pos;
      endcase
      if (step != MS_PT3 && step != MS_ACC) begin
        step <= mstep_t'(step + 4'd1);
      end
    end

    // Numerators of the two divisions; their range keeps these exact.
    if (state == ST_NUMER) begin
      n2         <= (pdiff << 1) + pdiff - (w0 << 1) - w1;
      n3         <= (64'd0 - (pdiff << 1)) + w0 + w1;
      div_second <= 1'b0;
    end

    if (state == ST_DIV_WAIT && div_done) begin
      div_second <= 1'b1;
    end

    // Output register.
    if (emit_load) begin
      res.position     <= out32(pos);
      res.velocity     <= out32(vel);
      res.acceleration <= out32(acc);
    end
  end

  chs_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  chs_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

// ===== design/chs_checker.sv =====
module chs_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input chs_pkg::req_t req,
  input logic          res_valid,
  input logic          res_stall,
  input chs_pkg::res_t res
);
  import chs_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A held result keeps its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // An accepted sample request keeps the block busy in the following cycle;
  // a plan with a short duration does not.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.op == OP_SAMPLE |=> req_stall)
    else $error("sample request did not occupy the block");

  // A new result only appears after the block was busy finishing it.
  a_res_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared while idle");

endmodule

bind cubic_hermite_segment_unit chs_checker u_chk (.*);
